// ===== hw/rtl/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg: shared types for the positional list engine
// Request and status codes, plus the control word broadcast to the cells.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int unsigned DefaultCapacity = 16;
  localparam int unsigned PosW            = 5;
  localparam int unsigned DataW           = 32;
  localparam int unsigned LenW            = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Broadcast to every cell in the cycle a request beat is taken.
  typedef struct packed {
    logic              ins_en;    // commit an insert
    logic              del_en;    // commit a delete
    logic [PosW-1:0]   position;  // 1-based target position
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/ple_cell.sv =====
// ----------------------------------------------------------------------------
// ple_cell: one storage slot of the list
// Holds one element; loads, shifts from a neighbor or holds, and drives its
// element onto the read bus when it is the addressed slot.
// ----------------------------------------------------------------------------
module ple_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                            clk_i,
  input  ple_pkg::cell_ctrl_t             ctrl_i,
  input  logic [ple_pkg::DataW-1:0]       value_i,
  input  logic [ple_pkg::DataW-1:0]       prev_data_i,
  input  logic [ple_pkg::DataW-1:0]       next_data_i,
  output logic [ple_pkg::DataW-1:0]       data_o,
  output logic [ple_pkg::DataW-1:0]       rd_data_o
);

  localparam int unsigned SlotPos = IDX + 1;

  logic [ple_pkg::DataW-1:0] data_q, data_d;
  logic                      hit, behind;

  assign hit    = (32'(ctrl_i.position) == SlotPos);
  assign behind = (32'(ctrl_i.position) <  SlotPos);

  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins_en) begin
      if (hit) begin
        data_d = value_i;
      end else if (behind) begin
        data_d = prev_data_i;
      end
    end else if (ctrl_i.del_en) begin
      if (hit || behind) begin
        data_d = next_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o    = data_q;
  assign rd_data_o = hit ? data_q : '0;

endmodule

// ===== hw/rtl/positional_list_engine.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine: ordered list of signed words, addressed by position
// Insert, delete or read at a 1-based position over a row of shift cells.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake             | payload
//  ----------+-----------+-----------------------+------------------------------
//  request   | in        | in_valid_i/in_ready_o | operation_i, position_i, value_i
//  result    | out       | out_valid_o/out_ready_i | status_o, length_o, read_value_o
//
//  Cycles: one request beat per cycle while no held result stalls it; its result is
//  registered and shows on the next cycle. The whole row of cells shifts in the cycle
//  the beat is taken, so throughput is set only by the result register draining.
//  Reset: clears the element count and the result valid; cell contents are
//  left alone (slots at or past the count are never read).
//  Stalls: a held result blocks a new request only while out_ready_i is low.
//
module positional_list_engine #(
  parameter int unsigned CAPACITY = ple_pkg::DefaultCapacity
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    operation_i,
  input  logic [ple_pkg::PosW-1:0]      position_i,
  input  logic signed [ple_pkg::DataW-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [ple_pkg::LenW-1:0]      length_o,
  output logic signed [ple_pkg::DataW-1:0] read_value_o
);

  // Count must hold CAPACITY itself; compares run at a width covering both
  // the count and the position field plus one.
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = ((CntW > ple_pkg::PosW) ? CntW : ple_pkg::PosW) + 1;

  logic [CntW-1:0]            count_q, count_d;
  logic                       out_valid_q;
  logic [1:0]                 status_q;
  logic [ple_pkg::LenW-1:0]   length_q;
  logic [ple_pkg::DataW-1:0]  rd_value_q;

  logic                       req_fire;
  logic [CmpW-1:0]            pos_ext, cnt_ext;
  logic                       pos_nonzero, ins_pos_ok, acc_pos_ok, full;
  ple_pkg::status_e           status_d;
  logic [ple_pkg::DataW-1:0]  rd_value_d;
  ple_pkg::cell_ctrl_t        ctrl;

  logic [ple_pkg::DataW-1:0]  cell_data [CAPACITY];
  logic [ple_pkg::DataW-1:0]  cell_rd   [CAPACITY];
  logic [ple_pkg::DataW-1:0]  rd_bus;

  // Take a new beat whenever the result register is empty or draining.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign req_fire   = in_valid_i && in_ready_o;

  // Position checks against the current count.
  assign pos_ext     = CmpW'(position_i);
  assign cnt_ext     = CmpW'(count_q);
  assign pos_nonzero = (position_i != '0);
  assign ins_pos_ok  = pos_nonzero && (pos_ext <= cnt_ext + CmpW'(1));
  assign acc_pos_ok  = pos_nonzero && (pos_ext <= cnt_ext);
  assign full        = (count_q == CntW'(CAPACITY));

  // Decode the request; unknown operations fall to the range error.
  always_comb begin
    status_d    = ple_pkg::ST_RANGE;
    rd_value_d  = '0;
    count_d     = count_q;
    ctrl        = '0;
    ctrl.position = position_i;
    unique case (operation_i)
      ple_pkg::OP_INSERT: begin
        if (ins_pos_ok) begin
          if (full) begin
            status_d = ple_pkg::ST_FULL;
          end else begin
            status_d    = ple_pkg::ST_DONE;
            ctrl.ins_en = req_fire;
            count_d     = count_q + CntW'(1);
          end
        end
      end
      ple_pkg::OP_DELETE: begin
        if (acc_pos_ok) begin
          status_d    = ple_pkg::ST_DONE;
          rd_value_d  = rd_bus;
          ctrl.del_en = req_fire;
          count_d     = count_q - CntW'(1);
        end
      end
      ple_pkg::OP_READ: begin
        if (acc_pos_ok) begin
          status_d   = ple_pkg::ST_DONE;
          rd_value_d = rd_bus;
        end
      end
      default: begin
        status_d = ple_pkg::ST_RANGE;
      end
    endcase
  end

  // Row of cells: each takes from its left neighbor on insert and from its
  // right neighbor on delete. The last cell recirculates its own word.
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    logic [ple_pkg::DataW-1:0] prev_data, next_data;
    if (gi == 0) begin : g_first
      assign prev_data = value_i;
    end else begin : g_mid
      assign prev_data = cell_data[gi-1];
    end
    if (gi == CAPACITY - 1) begin : g_last
      assign next_data = cell_data[gi];
    end else begin : g_inner
      assign next_data = cell_data[gi+1];
    end

    ple_cell #(
      .IDX (gi)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .value_i     (value_i),
      .prev_data_i (prev_data),
      .next_data_i (next_data),
      .data_o      (cell_data[gi]),
      .rd_data_o   (cell_rd[gi])
    );
  end

  // At most one cell matches the position, so OR the gated words together.
  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_bus = rd_bus | cell_rd[i];
    end
  end

  // Hold count and the result register; advance on an accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      status_q   <= status_d;
      length_q   <= ple_pkg::LenW'(count_d);
      rd_value_q <= rd_value_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign length_o     = length_q;
  assign read_value_o = rd_value_q;

  // Count never passes the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("element count above capacity");

  // A completed insert grows the list by one.
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && status_d == ple_pkg::ST_DONE && operation_i == ple_pkg::OP_INSERT)
    |=> count_q == $past(count_q) + CntW'(1))
    else $error("insert did not grow the list");

  // A rejected request leaves the count alone.
  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && status_d != ple_pkg::ST_DONE) |=> $stable(count_q))
    else $error("rejected request changed the count");

  // A pending result reports the live length.
  a_length_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> length_o == ple_pkg::LenW'(count_q))
    else $error("reported length disagrees with count");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the positional list engine
// Drive insert, delete and read beats and predict each result beat from a
// private copy of the list. Compare every result field by field, in order,
// across phases with and without idling on either channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned LIST_CAP    = 16;
  localparam int unsigned PHASE_ITEMS = 170;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned TAIL_CYCLES = 10;

  typedef struct {
    logic [1:0]                 op;
    logic [ple_pkg::PosW-1:0]   pos;
    logic signed [31:0]         val;
  } list_request_t;

  typedef struct {
    ple_pkg::status_e           status;
    logic [ple_pkg::LenW-1:0]   length;
    logic signed [31:0]         read_value;
  } list_result_t;

  // DUT ports; every input holds a known value from time zero
  logic                       clk_i        = 1'b0;
  logic                       rst_ni       = 1'b0;
  logic                       in_valid_i   = 1'b0;
  logic                       in_ready_o;
  logic [1:0]                 operation_i  = '0;
  logic [ple_pkg::PosW-1:0]   position_i   = '0;
  logic signed [31:0]         value_i      = '0;
  logic                       out_valid_o;
  logic                       out_ready_i  = 1'b0;
  logic [1:0]                 status_o;
  logic [ple_pkg::LenW-1:0]   length_o;
  logic signed [31:0]         read_value_o;

  // Beats waiting to go out, and result beats predicted but not yet seen
  list_request_t request_queue[$];
  list_result_t  expected_results[$];

  // Private copy of the list, advanced once per accepted request beat
  logic signed [31:0] list_mem [LIST_CAP];
  int                 list_len = 0;

  // Length the generator assumes once every queued beat has been taken
  int   plan_len = 0;
  logic growing  = 1'b1;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned error_count = 0;
  int unsigned n_checked   = 0;
  int unsigned n_insert    = 0;
  int unsigned n_delete    = 0;
  int unsigned n_read      = 0;
  int unsigned n_bad_op    = 0;
  int unsigned n_full      = 0;
  int unsigned n_range     = 0;
  int unsigned cycle_count;

  positional_list_engine #(
    .CAPACITY(LIST_CAP)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .length_o    (length_o),
    .read_value_o(read_value_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Apply one request to the private list and return the result it earns.
  // The position check always comes before the full check on insert.
  function automatic list_result_t list_apply(logic [1:0] op,
                                              logic [ple_pkg::PosW-1:0] pos,
                                              logic signed [31:0] val);
    list_result_t res;
    int           p;
    int           idx;
    res.status     = ple_pkg::ST_RANGE;
    res.read_value = '0;
    p              = int'(pos);
    case (op)
      ple_pkg::OP_INSERT: begin
        if (p >= 1 && p <= list_len + 1) begin
          if (list_len >= LIST_CAP) begin
            res.status = ple_pkg::ST_FULL;
          end else begin
            for (idx = list_len; idx > p - 1; idx--) list_mem[idx] = list_mem[idx-1];
            list_mem[p-1] = val;
            list_len++;
            res.status = ple_pkg::ST_DONE;
          end
        end
      end
      ple_pkg::OP_DELETE: begin
        if (p >= 1 && p <= list_len) begin
          res.read_value = list_mem[p-1];
          for (idx = p - 1; idx + 1 < list_len; idx++) list_mem[idx] = list_mem[idx+1];
          list_len--;
          res.status = ple_pkg::ST_DONE;
        end
      end
      ple_pkg::OP_READ: begin
        if (p >= 1 && p <= list_len) begin
          res.read_value = list_mem[p-1];
          res.status     = ple_pkg::ST_DONE;
        end
      end
      default: ;  // unknown code: reject, list untouched
    endcase
    res.length = ple_pkg::LenW'(list_len);
    return res;
  endfunction

  // Queue one request and track the length it leaves behind
  task automatic push_request(logic [1:0] op, int pos, logic signed [31:0] val);
    list_request_t req;
    req.op  = op;
    req.pos = ple_pkg::PosW'(pos);
    req.val = val;
    request_queue.push_back(req);
    if (op == ple_pkg::OP_INSERT && pos >= 1 && pos <= plan_len + 1 &&
        plan_len < LIST_CAP) begin
      plan_len++;
    end else if (op == ple_pkg::OP_DELETE && pos >= 1 && pos <= plan_len) begin
      plan_len--;
    end
  endtask

  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(7) != 0) return $urandom;
    case ($urandom_range(4))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0001;
      default: return 32'h0000_0000;
    endcase
  endfunction

  // Mostly well-formed requests that swing the list between empty and full,
  // with a sprinkle of arbitrary codes and positions
  task automatic add_random_request();
    int         r;
    int         hi;
    int         pos;
    logic [1:0] op;
    if (plan_len == LIST_CAP && $urandom_range(3) == 0) begin
      growing = 1'b0;
    end else if (plan_len == 0 && $urandom_range(3) == 0) begin
      growing = 1'b1;
    end else if ($urandom_range(49) == 0) begin
      growing = !growing;
    end
    if ($urandom_range(99) < 6) begin
      op  = 2'($urandom_range(3));
      pos = $urandom_range(31);
    end else begin
      r = $urandom_range(99);
      if (growing) begin
        if (r < 55)      op = ple_pkg::OP_INSERT;
        else if (r < 75) op = ple_pkg::OP_DELETE;
        else             op = ple_pkg::OP_READ;
      end else begin
        if (r < 20)      op = ple_pkg::OP_INSERT;
        else if (r < 70) op = ple_pkg::OP_DELETE;
        else             op = ple_pkg::OP_READ;
      end
      hi = (op == ple_pkg::OP_INSERT) ? plan_len + 1 : plan_len;
      if (hi == 0 || $urandom_range(9) == 0) pos = $urandom_range(31);
      else                                    pos = $urandom_range(hi, 1);
    end
    push_request(op, pos, pick_value());
  endtask

  // Hold the generator until every beat is out and every result is back
  task automatic drain_all();
    while (request_queue.size() != 0 || in_valid_i || expected_results.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic run_phase(int unsigned send_pct, int unsigned recv_pct);
    int unsigned k;
    drain_all();
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (k = 0; k < PHASE_ITEMS; k++) add_random_request();
  endtask

  // Request driver: advance to the next beat once the current one is taken,
  // and predict the result of each beat at the edge that takes it
  always @(posedge clk_i or negedge rst_ni) begin
    list_request_t req;
    list_result_t  res;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      operation_i <= '0;
      position_i  <= '0;
      value_i     <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        res = list_apply(operation_i, position_i, value_i);
        expected_results.push_back(res);
        case (operation_i)
          ple_pkg::OP_INSERT: n_insert++;
          ple_pkg::OP_DELETE: n_delete++;
          ple_pkg::OP_READ:   n_read++;
          default:            n_bad_op++;
        endcase
        if (res.status == ple_pkg::ST_FULL)  n_full++;
        if (res.status == ple_pkg::ST_RANGE) n_range++;
      end
      // The beat slot is free when nothing is offered or the offer was taken
      if (!in_valid_i || in_ready_o) begin
        if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req = request_queue.pop_front();
          in_valid_i  <= 1'b1;
          operation_i <= req.op;
          position_i  <= req.pos;
          value_i     <= req.val;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each taken result beat against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t exp_res;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: result beat with nothing expected: status %0d length %0d value %0d",
                   $time, status_o, length_o, read_value_o);
        end else begin
          exp_res = expected_results.pop_front();
          n_checked++;
          if (status_o !== exp_res.status) begin
            error_count++;
            $display("%0t: status expected %0d, got %0d", $time, exp_res.status, status_o);
          end
          if (length_o !== exp_res.length) begin
            error_count++;
            $display("%0t: length expected %0d, got %0d", $time, exp_res.length, length_o);
          end
          if (read_value_o !== exp_res.read_value) begin
            error_count++;
            $display("%0t: read_value expected %0d, got %0d",
                     $time, exp_res.read_value, read_value_o);
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk_i);
    $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    int unsigned k;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: rejects on the empty list, unknown code
    push_request(ple_pkg::OP_READ,   1, 32'h0);
    push_request(ple_pkg::OP_DELETE, 1, 32'h0);
    push_request(ple_pkg::OP_INSERT, 0, 32'h1234_5678);
    push_request(ple_pkg::OP_INSERT, 2, 32'h1234_5678);
    push_request(2'b11,              1, 32'h0);
    // Fill to capacity through front, back and middle inserts
    for (k = 0; k < LIST_CAP; k++) begin
      case (k % 3)
        0: push_request(ple_pkg::OP_INSERT, 1,
                        (k == 0) ? 32'h8000_0000 : $urandom);
        1: push_request(ple_pkg::OP_INSERT, plan_len + 1,
                        (k == 1) ? 32'h7fff_ffff : $urandom);
        default: push_request(ple_pkg::OP_INSERT, plan_len / 2 + 1,
                              (k == 2) ? 32'hffff_ffff : 32'h0);
      endcase
    end
    // Full list: front and back inserts report full, reading past the end
    // and inserting far past it are range errors
    push_request(ple_pkg::OP_INSERT, 1,  32'h5555_aaaa);
    push_request(ple_pkg::OP_INSERT, 17, 32'haaaa_5555);
    push_request(ple_pkg::OP_READ,   16, 32'h0);
    push_request(ple_pkg::OP_READ,   17, 32'h0);
    push_request(ple_pkg::OP_DELETE, 16, 32'h0);
    push_request(ple_pkg::OP_DELETE, 1,  32'h0);
    push_request(ple_pkg::OP_INSERT, 31, 32'h0);

    // Random: each phase first lets everything outstanding drain
    run_phase(0, 0);
    run_phase(45, 0);
    run_phase(0, 45);
    run_phase(34, 34);
    drain_all();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Checked %0d results: %0d inserts, %0d deletes, %0d reads, %0d unknown codes",
             n_checked, n_insert, n_delete, n_read, n_bad_op);
    $display("Rejections seen: %0d out of range, %0d on a full list", n_range, n_full);
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
